>>> sv/spherize_vertex_assert.svh
// spherize_vertex_assert.svh: concurrent assertion macros for the vertex pipeline
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef SPHERIZE_VERTEX_ASSERT_SVH
`define SPHERIZE_VERTEX_ASSERT_SVH
// same-cycle implication
`define SPV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SPV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> sv/spv_pkg.sv
// spv_pkg: widths, register indexes and pipeline payload types of the vertex pipeline
// no dependencies
package spv_pkg;

  localparam int CoordW  = 32;
  localparam int DiffW   = 33;
  localparam int WeightW = 17;
  localparam int RadiusW = 31;
  localparam int RootW   = 33;
  localparam int RadW    = 66;
  localparam int NumW    = 63;
  localparam int QuotW   = 31;
  localparam int CfgIdxW = 3;

  localparam logic [WeightW-1:0] OneQ16 = 17'd65536;

  localparam logic [CfgIdxW-1:0] CfgCenterX = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCenterY = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCenterZ = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRatio   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRadius  = 3'd4;

  // per-vertex payload carried alongside the square root
  typedef struct packed {
    logic                         flag;
    logic [2:0]                   neg;
    logic [2:0][CoordW-1:0]       mag;
    logic [WeightW-1:0]           t16;
  } spv_item_t;

  // payload carried alongside the dividers
  typedef struct packed {
    logic                         flag;
    logic [2:0]                   neg;
    logic [2:0][CoordW-1:0]       mag;
    logic [RootW-1:0]             r;
    logic [RootW-1:0]             newlen;
  } spv_dctl_t;

endpackage

>>> sv/spv_isqrt.sv
// spv_isqrt: fully pipelined integer square root, one result bit per stage
// depends on spv_pkg
module spv_isqrt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [spv_pkg::RadW-1:0]        rad_i,
  input  spv_pkg::spv_item_t              item_i,
  output logic                            valid_o,
  output logic [spv_pkg::RootW-1:0]       root_o,
  output spv_pkg::spv_item_t              item_o
);

  localparam int Steps = spv_pkg::RootW;
  localparam int RemW  = spv_pkg::RootW + 3;

  logic                           vld_q  [0:Steps];
  logic [RemW-1:0]                rem_q  [0:Steps];
  logic [spv_pkg::RootW-1:0]      res_q  [0:Steps];
  logic [spv_pkg::RadW-1:0]       rad_q  [0:Steps];
  spv_pkg::spv_item_t             item_q [0:Steps];

  assign vld_q[0]  = valid_i;
  assign rem_q[0]  = '0;
  assign res_q[0]  = '0;
  assign rad_q[0]  = rad_i;
  assign item_q[0] = item_i;

  for (genvar j = 0; j < Steps; j++) begin : g_stage
    logic [RemW-1:0]           remn;
    logic [RemW-1:0]           trial;
    logic                      ge;
    logic [RemW-1:0]           rem_d;
    logic [spv_pkg::RootW-1:0] res_d;

    always_comb begin
      remn  = {rem_q[j][RemW-3:0], rad_q[j][spv_pkg::RadW-1 -: 2]};
      trial = {1'b0, res_q[j], 2'b01};
      ge    = (remn >= trial);
      rem_d = ge ? (remn - trial) : remn;
      res_d = {res_q[j][spv_pkg::RootW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1]  <= rem_d;
        res_q[j+1]  <= res_d;
        rad_q[j+1]  <= {rad_q[j][spv_pkg::RadW-3:0], 2'b00};
        item_q[j+1] <= item_q[j];
      end
    end
  end

  assign valid_o = vld_q[Steps];
  assign root_o  = res_q[Steps];
  assign item_o  = item_q[Steps];

endmodule

>>> sv/spv_div.sv
// spv_div: three pipelined restoring dividers sharing one divisor, one quotient bit per stage
// depends on spv_pkg
module spv_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic [2:0][spv_pkg::NumW-1:0]        num_i,
  input  spv_pkg::spv_dctl_t                   ctl_i,
  output logic                                 valid_o,
  output logic [2:0][spv_pkg::QuotW-1:0]       quo_o,
  output spv_pkg::spv_dctl_t                   ctl_o
);

  localparam int Steps = spv_pkg::QuotW;
  localparam int RemW  = spv_pkg::RootW;

  logic                                vld_q [0:Steps];
  logic [2:0][RemW-1:0]                rem_q [0:Steps];
  logic [2:0][spv_pkg::QuotW-1:0]      low_q [0:Steps];
  logic [2:0][spv_pkg::QuotW-1:0]      quo_q [0:Steps];
  spv_pkg::spv_dctl_t                  ctl_q [0:Steps];

  assign vld_q[0] = valid_i;
  assign ctl_q[0] = ctl_i;
  assign quo_q[0] = '0;
  for (genvar k = 0; k < 3; k++) begin : g_init
    // upper part of the dividend is already below the divisor
    assign rem_q[0][k] = {1'b0, num_i[k][spv_pkg::NumW-1:spv_pkg::QuotW]};
    assign low_q[0][k] = num_i[k][spv_pkg::QuotW-1:0];
  end

  for (genvar j = 0; j < Steps; j++) begin : g_stage
    logic [2:0][RemW:0]                sh;
    logic [2:0]                        ge;
    logic [2:0][RemW-1:0]              rem_d;
    logic [2:0][spv_pkg::QuotW-1:0]    quo_d;
    logic [2:0][spv_pkg::QuotW-1:0]    low_d;

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        sh[k]    = {rem_q[j][k], low_q[j][k][spv_pkg::QuotW-1]};
        ge[k]    = (sh[k] >= {1'b0, ctl_q[j].r});
        rem_d[k] = ge[k] ? RemW'(sh[k] - {1'b0, ctl_q[j].r}) : sh[k][RemW-1:0];
        quo_d[k] = {quo_q[j][k][spv_pkg::QuotW-2:0], ge[k]};
        low_d[k] = {low_q[j][k][spv_pkg::QuotW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1] <= rem_d;
        quo_q[j+1] <= quo_d;
        low_q[j+1] <= low_d;
        ctl_q[j+1] <= ctl_q[j];
      end
    end
  end

  assign valid_o = vld_q[Steps];
  assign quo_o   = quo_q[Steps];
  assign ctl_o   = ctl_q[Steps];

endmodule

>>> sv/spherize_vertex.sv
// spherize_vertex: moves a vertex along its direction from a centre toward a target radius
// depends on spv_pkg, spv_isqrt, spv_div and spherize_vertex_assert.svh
//
// input stream s_axis carries one vertex per transaction: position, weight and
// the skip and no_action flags. output stream m_axis carries the moved position
// and a flag that is set when the position was recomputed.
// one vertex enters per cycle unless the output buffer is full: the square root
// takes one root bit per stage (33 stages) and each of the three dividers one
// quotient bit per stage (31 stages), all fully pipelined.
// the pipeline feeds a two-entry output buffer; s_axis_tready_o drops only when
// that buffer is full, so a stalled receiver freezes the pipeline in place and
// no transaction is lost or repeated.
// configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i; the user must
// write it only while the block is idle, as the block does not enforce this.
// indexes past the register list are ignored. reset clears the configuration (centre,
// ratio, radius to zero) and the valid bits, emptying the pipeline and output buffer.
`include "spherize_vertex_assert.svh"

module spherize_vertex (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // pos_x, pos_y, pos_z, weight, zero fill
  input  logic [119:0]  s_axis_tdata_i,
  // skip, no_action
  input  logic [1:0]    s_axis_tuser_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // out_x, out_y, out_z
  output logic [95:0]   m_axis_tdata_o,
  // moved
  output logic          m_axis_tuser_o,
  input  logic          cfg_we_i,
  input  logic [spv_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]   cfg_data_i
);

  localparam int CW = spv_pkg::CoordW;
  localparam int WW = spv_pkg::WeightW;
  localparam int RW = spv_pkg::RootW;

  // configuration
  logic [2:0][CW-1:0]            center_q;
  logic [WW-1:0]                 ratio_q;
  logic [spv_pkg::RadiusW-1:0]   radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= '0;
      ratio_q  <= '0;
      radius_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        spv_pkg::CfgCenterX: center_q[0] <= cfg_data_i;
        spv_pkg::CfgCenterY: center_q[1] <= cfg_data_i;
        spv_pkg::CfgCenterZ: center_q[2] <= cfg_data_i;
        spv_pkg::CfgRatio:   ratio_q     <= cfg_data_i[WW-1:0];
        spv_pkg::CfgRadius:  radius_q    <= cfg_data_i[spv_pkg::RadiusW-1:0];
        default: ;
      endcase
    end
  end

  // output buffer control
  logic [1:0] cnt_q, cnt_d;
  logic       en, push, pop;

  assign en              = (cnt_q != 2'd2);
  assign s_axis_tready_o = en;

  // stage 1: offsets from the centre and ratio times weight
  logic                       v1_q;
  logic [2:0][spv_pkg::DiffW-1:0] d1_q, d1_d;
  logic [2*WW-1:0]            blend1_q, blend1_d;
  logic                       flag1_q;
  logic [WW-1:0]              ratio_sat, w_raw, w_sat;

  always_comb begin
    ratio_sat = (ratio_q > spv_pkg::OneQ16) ? spv_pkg::OneQ16 : ratio_q;
    w_raw     = s_axis_tdata_i[3*CW +: WW];
    w_sat     = (w_raw > spv_pkg::OneQ16) ? spv_pkg::OneQ16 : w_raw;
    blend1_d  = ratio_sat * w_sat;
    for (int k = 0; k < 3; k++) begin
      d1_d[k] = {s_axis_tdata_i[CW*k+CW-1], s_axis_tdata_i[CW*k +: CW]}
              - {center_q[k][CW-1], center_q[k]};
    end
  end

  // stage 2: magnitudes and rounded blend
  logic                       v2_q;
  spv_pkg::spv_item_t         it2_q, it2_d;
  logic [2*WW-1:0]            blend_rnd;

  always_comb begin
    blend_rnd    = blend1_q + (2*WW)'(32768);
    it2_d.flag   = flag1_q;
    it2_d.t16    = blend_rnd[16 +: WW];
    for (int k = 0; k < 3; k++) begin
      it2_d.neg[k] = d1_q[k][spv_pkg::DiffW-1];
      it2_d.mag[k] = d1_q[k][spv_pkg::DiffW-1] ? CW'(-d1_q[k]) : d1_q[k][CW-1:0];
    end
  end

  // stage 3: squares
  logic                       v3_q;
  spv_pkg::spv_item_t         it3_q;
  logic [2:0][2*CW-1:0]       sq3_q, sq3_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq3_d[k] = it2_q.mag[k] * it2_q.mag[k];
    end
  end

  // stage 4: sum of squares
  logic                       v4_q;
  spv_pkg::spv_item_t         it4_q;
  logic [spv_pkg::RadW-1:0]   sum4_q, sum4_d;

  assign sum4_d = spv_pkg::RadW'(sq3_q[0]) + spv_pkg::RadW'(sq3_q[1])
                + spv_pkg::RadW'(sq3_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_q     <= d1_d;
      blend1_q <= blend1_d;
      flag1_q  <= s_axis_tuser_i[0] | s_axis_tuser_i[1];
      it2_q    <= it2_d;
      it3_q    <= it2_q;
      sq3_q    <= sq3_d;
      it4_q    <= it3_q;
      sum4_q   <= sum4_d;
    end
  end

  // square root
  logic                       vs_w;
  logic [RW-1:0]              root_w;
  spv_pkg::spv_item_t         its_w;

  spv_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v4_q),
    .rad_i   (sum4_q),
    .item_i  (it4_q),
    .valid_o (vs_w),
    .root_o  (root_w),
    .item_o  (its_w)
  );

  // stage 5: blend products
  logic                       v5_q;
  spv_pkg::spv_item_t         it5_q;
  logic [RW-1:0]              r5_q;
  logic [RW+WW-1:0]           a5_q, a5_d;
  logic [spv_pkg::RadiusW+WW-1:0] b5_q, b5_d;

  assign a5_d = root_w * (spv_pkg::OneQ16 - its_w.t16);
  assign b5_d = radius_q * its_w.t16;

  // stage 6: new length and dividends
  logic                       v6_q;
  spv_pkg::spv_dctl_t         ctl6_q, ctl6_d;
  logic [2:0][spv_pkg::NumW-1:0] num6_q, num6_d;
  logic [RW+WW:0]             nl_sum;

  always_comb begin
    nl_sum         = (RW+WW+1)'(a5_q) + (RW+WW+1)'(b5_q) + (RW+WW+1)'(32768);
    ctl6_d.flag    = it5_q.flag;
    ctl6_d.neg     = it5_q.neg;
    ctl6_d.mag     = it5_q.mag;
    ctl6_d.r       = r5_q;
    ctl6_d.newlen  = nl_sum[16 +: RW];
    for (int k = 0; k < 3; k++) begin
      // rounded quotient: add half the divisor up front
      num6_d[k] = {1'b0, it5_q.mag[k], 30'd0} + spv_pkg::NumW'(r5_q >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v5_q <= vs_w;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      it5_q  <= its_w;
      r5_q   <= root_w;
      a5_q   <= a5_d;
      b5_q   <= b5_d;
      ctl6_q <= ctl6_d;
      num6_q <= num6_d;
    end
  end

  // direction components
  logic                             vd_w;
  logic [2:0][spv_pkg::QuotW-1:0]   quo_w;
  spv_pkg::spv_dctl_t               ctld_w;

  spv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v6_q),
    .num_i   (num6_q),
    .ctl_i   (ctl6_q),
    .valid_o (vd_w),
    .quo_o   (quo_w),
    .ctl_o   (ctld_w)
  );

  // stage 7: scale direction by new length
  logic                       v7_q;
  logic                       flag7_q, rz7_q;
  logic [2:0]                 neg7_q;
  logic [2:0][CW-1:0]         mag7_q;
  logic [2:0][2*CW-1:0]       prod7_q, prod7_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod7_d[k] = quo_w[k] * ctld_w.newlen;
    end
  end

  // stage 8: rounded offsets, pass-through and zero-length cases
  logic                       v8_q;
  logic                       flag8_q;
  logic [2:0]                 neg8_q;
  logic [2:0][CW+1:0]         off8_q, off8_d;
  logic [2*CW-1:0]            prod_rnd [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_rnd[k] = prod7_q[k] + (2*CW)'(64'd1 << 29);
      if (flag7_q) begin
        off8_d[k] = (CW+2)'(mag7_q[k]);
      end else if (rz7_q) begin
        off8_d[k] = '0;
      end else begin
        off8_d[k] = prod_rnd[k][30 +: CW+2];
      end
    end
  end

  // stage 9: add to centre and saturate
  logic                       v9_q;
  logic                       moved9_q;
  logic [2:0][CW-1:0]         out9_q, out9_d;
  logic [CW+2:0]              res9 [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      res9[k] = neg8_q[k]
              ? ({{3{center_q[k][CW-1]}}, center_q[k]} - {1'b0, off8_q[k]})
              : ({{3{center_q[k][CW-1]}}, center_q[k]} + {1'b0, off8_q[k]});
      if (res9[k][CW+2:CW-1] == 4'b0000 || res9[k][CW+2:CW-1] == 4'b1111) begin
        out9_d[k] = res9[k][CW-1:0];
      end else if (res9[k][CW+2]) begin
        out9_d[k] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        out9_d[k] = {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else if (en) begin
      v7_q <= vd_w;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      flag7_q  <= ctld_w.flag;
      rz7_q    <= (ctld_w.r == '0);
      neg7_q   <= ctld_w.neg;
      mag7_q   <= ctld_w.mag;
      prod7_q  <= prod7_d;
      flag8_q  <= flag7_q;
      neg8_q   <= neg7_q;
      off8_q   <= off8_d;
      moved9_q <= ~flag8_q;
      out9_q   <= out9_d;
    end
  end

  // two-entry output buffer: head drives the port, skid catches one more
  logic [3*CW-1:0] head_data_q, skid_data_q;
  logic            head_moved_q, skid_moved_q;

  assign push = en & v9_q;
  assign pop  = m_axis_tvalid_o & m_axis_tready_i;

  always_comb begin
    cnt_d = cnt_q;
    case (cnt_q)
      2'd0: if (push) cnt_d = 2'd1;
      2'd1: if (push && !pop) cnt_d = 2'd2;
            else if (!push && pop) cnt_d = 2'd0;
      2'd2: if (pop) cnt_d = 2'd1;
      default: cnt_d = 2'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_q == 2'd2) begin
      if (pop) begin
        head_data_q  <= skid_data_q;
        head_moved_q <= skid_moved_q;
      end
    end else if (push) begin
      if (cnt_q == 2'd0 || pop) begin
        head_data_q  <= out9_q;
        head_moved_q <= moved9_q;
      end else begin
        skid_data_q  <= out9_q;
        skid_moved_q <= moved9_q;
      end
    end
  end

  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tdata_o  = head_data_q;
  assign m_axis_tuser_o  = head_moved_q;

  `SPV_ASSERT_NXT(a_stall_freezes_tail, !en, $stable(v9_q), "pipeline moved while stalled")
  `SPV_ASSERT_NXT(a_full_buffer_kept, (cnt_q == 2'd2) && !pop, cnt_q == 2'd2,
    "full output buffer lost an entry")
  `SPV_ASSERT_NXT(a_last_entry_drains, (cnt_q == 2'd1) && pop && !push, !m_axis_tvalid_o,
    "output buffer did not drain")

endmodule

>>> dv/tb_spherize_vertex.sv
// tb_spherize_vertex: self-checking bench for the vertex spherize pipeline
// depends on spv_pkg and spherize_vertex; predicts each result in place and
// compares it with m_axis under random idling and back-pressure
`timescale 1ns / 1ps

module tb_spherize_vertex;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [16:0] weight;
    logic        skip;
    logic        no_action;
  } vertex_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        moved;
  } moved_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_tvalid;
  logic         s_tready;
  logic [119:0] s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [95:0]  m_tdata;
  logic         m_tuser;
  logic         cfg_we;
  logic [spv_pkg::CfgIdxW-1:0] cfg_idx;
  logic [31:0]  cfg_data;

  spherize_vertex dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tuser_o(m_tuser),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  // local copy of the configuration
  logic signed [31:0] ctr [3];
  logic [16:0] ratio_q;
  logic [30:0] radius_q;

  vertex_t pending_q[$];
  moved_t  expected_q[$];
  int      n_errors;
  bit      tx_idle_on;
  bit      rx_idle_on;
  int      rx_hold;

  function automatic logic [32:0] isqrt66(logic [65:0] v);
    logic [67:0] rem;
    logic [33:0] res;
    logic [67:0] trial;
    rem = '0;
    res = '0;
    for (int k = 32; k >= 0; k--) begin
      rem = (rem << 2) | 68'(v[2*k +: 2]);
      trial = (68'(res) << 2) | 68'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        res = (res << 1) | 34'd1;
      end else begin
        res = res << 1;
      end
    end
    return res[32:0];
  endfunction

  function automatic moved_t spherize(vertex_t v);
    moved_t o;
    logic signed [33:0] d [3];
    logic [32:0] m [3];
    logic [65:0] sum;
    logic [32:0] r;
    logic [16:0] rt, w;
    logic [127:0] t16, newlen, u, off;
    logic signed [34:0] res;
    logic [31:0] outv [3];
    logic signed [31:0] p [3];
    if (v.skip || v.no_action) begin
      o.x = v.x; o.y = v.y; o.z = v.z; o.moved = 1'b0;
      return o;
    end
    p[0] = v.x; p[1] = v.y; p[2] = v.z;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = 34'(p[i]) - 34'(ctr[i]);
      m[i] = d[i] < 0 ? 33'(-d[i]) : 33'(d[i]);
      sum = sum + 66'(m[i]) * 66'(m[i]);
    end
    r = isqrt66(sum);
    rt = ratio_q > spv_pkg::OneQ16 ? spv_pkg::OneQ16 : ratio_q;
    w = v.weight > spv_pkg::OneQ16 ? spv_pkg::OneQ16 : v.weight;
    t16 = (128'(rt) * 128'(w) + 128'd32768) >> 16;
    newlen = (128'(r) * (128'd65536 - t16) + 128'(radius_q) * t16 + 128'd32768) >> 16;
    for (int i = 0; i < 3; i++) begin
      res = 35'(ctr[i]);
      if (r != 0) begin
        u = ((128'(m[i]) << 30) + 128'(r >> 1)) / 128'(r);
        off = (u * newlen + (128'd1 << 29)) >> 30;
        if (d[i] < 0) res = res - 35'(off);
        else res = res + 35'(off);
      end
      if (res > 35'sh7FFFFFFF) outv[i] = 32'h7FFFFFFF;
      else if (res < -35'sh80000000) outv[i] = 32'h80000000;
      else outv[i] = res[31:0];
    end
    o.x = outv[0]; o.y = outv[1]; o.z = outv[2]; o.moved = 1'b1;
    return o;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // driver: offers the head of the pending queue
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_q.push_back(spherize(pending_q.pop_front()));
      end
      if (!s_tvalid || s_tready) begin
        if (pending_q.size() > 0 && !(tx_idle_on && $urandom_range(99) < 25)) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {7'd0, pending_q[0].weight, pending_q[0].z, pending_q[0].y,
                       pending_q[0].x};
          s_tuser  <= {pending_q[0].no_action, pending_q[0].skip};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    moved_t got, want;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser};
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: %h", got);
          n_errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.x !== want.x) begin
            $error("out_x expected %h got %h", want.x, got.x); n_errors++;
          end
          if (got.y !== want.y) begin
            $error("out_y expected %h got %h", want.y, got.y); n_errors++;
          end
          if (got.z !== want.z) begin
            $error("out_z expected %h got %h", want.z, got.z); n_errors++;
          end
          if (got.moved !== want.moved) begin
            $error("moved expected %b got %b", want.moved, got.moved); n_errors++;
          end
        end
      end
      if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !(rx_idle_on && $urandom_range(99) < 25);
      end
    end
  end

  task automatic write_reg(logic [spv_pkg::CfgIdxW-1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      spv_pkg::CfgCenterX: ctr[0] = val;
      spv_pkg::CfgCenterY: ctr[1] = val;
      spv_pkg::CfgCenterZ: ctr[2] = val;
      spv_pkg::CfgRatio:   ratio_q = val[16:0];
      spv_pkg::CfgRadius:  radius_q = val[30:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || s_tvalid || expected_q.size() > 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord(logic signed [31:0] c);
    case ($urandom_range(3))
      0: return $urandom();
      1: return c + 32'($signed($urandom_range(2000)) - 1000);
      2: return c + 32'($signed($urandom_range(32'h00400000)) - 32'sh00200000);
      default: return $urandom_range(1) ? 32'h7FFFFFFF - $urandom_range(65536)
                                         : 32'h80000000 + $urandom_range(65536);
    endcase
  endfunction

  function automatic vertex_t rand_vertex();
    vertex_t v;
    v.x = rand_coord(ctr[0]);
    v.y = rand_coord(ctr[1]);
    v.z = rand_coord(ctr[2]);
    case ($urandom_range(3))
      0: v.weight = spv_pkg::OneQ16;
      1: v.weight = 17'($urandom_range(17'h1FFFF));
      default: v.weight = 17'($urandom_range(65536));
    endcase
    v.skip = $urandom_range(9) == 0;
    v.no_action = $urandom_range(9) == 0;
    return v;
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) pending_q.push_back(rand_vertex());
    drain();
  endtask

  initial begin
    n_errors = 0; tx_idle_on = 1'b0; rx_idle_on = 1'b0; rx_hold = 0;
    ctr[0] = 0; ctr[1] = 0; ctr[2] = 0; ratio_q = 0; radius_q = 0;
    cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset configuration, then a middling one
    pending_q.push_back({32'd65536, 32'd0, 32'd0, 17'd65536, 1'b0, 1'b0});
    pending_q.push_back({32'h0, 32'h0, 32'h0, 17'd0, 1'b0, 1'b0});
    drain();
    write_reg(spv_pkg::CfgCenterX, 32'h00010000);
    write_reg(spv_pkg::CfgCenterY, 32'hFFFE0000);
    write_reg(spv_pkg::CfgCenterZ, 32'h00008000);
    write_reg(spv_pkg::CfgRatio, 32'd65536);
    write_reg(spv_pkg::CfgRadius, 32'h00050000);
    write_reg(3'd7, 32'hFFFFFFFF);  // index past the list, ignored
    pending_q.push_back({32'h00010000, 32'hFFFE0000, 32'h00008000, 17'd65536, 1'b0, 1'b0});
    pending_q.push_back({32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 17'd65536, 1'b0, 1'b0});
    pending_q.push_back({32'h80000000, 32'h80000000, 32'h80000000, 17'd65536, 1'b0, 1'b0});
    pending_q.push_back({32'h7FFFFFFF, 32'h80000000, 32'h0, 17'h1FFFF, 1'b0, 1'b0});
    pending_q.push_back({32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 17'd30000, 1'b1, 1'b0});
    pending_q.push_back({32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA, 17'd1, 1'b0, 1'b1});
    pending_q.push_back({32'h00020000, 32'hFFFE0000, 32'h00008000, 17'd0, 1'b1, 1'b1});
    pending_q.push_back({32'h00020000, 32'hFFFE0000, 32'h00008000, 17'd32768, 1'b0, 1'b0});
    drain();
    // extreme settings: ratio above one, largest radius, centre at the corners in x and y
    write_reg(spv_pkg::CfgRatio, 32'h1FFFF);
    write_reg(spv_pkg::CfgRadius, 32'h7FFFFFFF);
    write_reg(spv_pkg::CfgCenterX, 32'h7FFFFFFF);
    write_reg(spv_pkg::CfgCenterY, 32'h80000000);
    write_reg(spv_pkg::CfgCenterZ, 32'h0);
    pending_q.push_back({32'h80000000, 32'h7FFFFFFF, 32'h00000001, 17'd65536, 1'b0, 1'b0});
    pending_q.push_back({32'h7FFFFFFF, 32'h80000000, 32'h0, 17'd65536, 1'b0, 1'b0});
    pending_q.push_back({32'h0, 32'h0, 32'h0, 17'd40000, 1'b0, 1'b0});
    drain();

    // random phases, each under a different setting
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(spv_pkg::CfgCenterX, ph == 0 ? 32'h0 : $urandom());
      write_reg(spv_pkg::CfgCenterY, $urandom_range(1) ? 32'h0 : $urandom());
      write_reg(spv_pkg::CfgCenterZ, $urandom() >> $urandom_range(31));
      write_reg(spv_pkg::CfgRatio,
                ph == 1 ? 32'd0 : (ph == 2 ? 32'h1FFFF : $urandom_range(65536)));
      write_reg(spv_pkg::CfgRadius, ph == 3 ? 32'd0 : $urandom() >> (1 + $urandom_range(30)));
      tx_idle_on = ph != 0;
      rx_idle_on = ph != 1;
      if (ph == 2) begin
        // receiver holds off long enough for the pipeline to back up
        for (int i = 0; i < 150; i++) pending_q.push_back(rand_vertex());
        @(posedge clk_i);
        rx_hold = 200;
        drain();
      end else begin
        random_phase(150);
      end
    end

    if (n_errors == 0) $display("tb_spherize_vertex: done, clean");
    else $display("tb_spherize_vertex: done, errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_spherize_vertex: done, errors");
    $finish;
  end

endmodule
